// File: rtl/i2c_mra_pkg.sv
// Shared types and constants for the I2C register-access master.
// Holds the payload structs, the configuration register indexes and the
// transfer item and status codes. No dependencies.
`default_nettype none

package i2c_mra_pkg;

  // Slave ACK is sampled this many times before the byte counts as refused
  localparam logic [1:0] ACK_TRIES = 2'd3;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REGISTER_ADDRESS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BYTE_COUNT       = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_READ_MODE        = 2'd3;

  // Byte being moved on the bus
  typedef enum logic [1:0] {
    ITEM_ADDR_W = 2'd0,
    ITEM_REG    = 2'd1,
    ITEM_DATA   = 2'd2,
    ITEM_ADDR_R = 2'd3
  } item_t;

  // Completion status codes
  localparam logic [2:0] STATUS_OK          = 3'd0;
  localparam logic [2:0] STATUS_ADDR_NACK   = 3'd1;
  localparam logic [2:0] STATUS_REG_NACK    = 3'd2;
  localparam logic [2:0] STATUS_WRITE_NACK  = 3'd3;
  localparam logic [2:0] STATUS_RADDR_NACK  = 3'd4;

  typedef struct packed {
    logic       go;
    logic       sda_in;
    logic [7:0] tx_data;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_listening;
    logic       tx_taken;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
  } out_item_t;

  function automatic logic [2:0] nack_status(input item_t it);
    logic [2:0] code;
    code = STATUS_OK;
    unique case (it)
      ITEM_ADDR_W: code = STATUS_ADDR_NACK;
      ITEM_REG:    code = STATUS_REG_NACK;
      ITEM_DATA:   code = STATUS_WRITE_NACK;
      ITEM_ADDR_R: code = STATUS_RADDR_NACK;
      default:     code = STATUS_OK;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: rtl/i2c_master_register_access.sv
// A result is registered into the output register and is valid in the cycle after its tick is accepted.
// Throughput: one tick per clock; the bus sequencer and the output register
// advance together, so a new tick is taken whenever the output register is free or drained.
// Reset (rst, synchronous, active high): sequencer idle, lines released,
// configuration and status cleared, output register empty.
// Bit-level I2C master for register writes and reads; depends on i2c_mra_pkg.
`default_nettype none

module i2c_master_register_access (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [i2c_mra_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [i2c_mra_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire i2c_mra_pkg::in_item_t               in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output i2c_mra_pkg::out_item_t                   out_data
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_SEND,
    PH_ACK,
    PH_RECV,
    PH_MACK,
    PH_STOP
  } phase_t;

  // configuration
  logic [6:0]  device_address;
  logic [7:0]  register_address;
  logic [15:0] byte_count;
  logic        read_mode;

  // sequencer state
  phase_t              phase, phase_next;
  logic [1:0]          tick_in_phase, tick_in_phase_next;
  logic [3:0]          bit_counter, bit_counter_next;
  logic [7:0]          shift_byte, shift_byte_next;
  logic [15:0]         bytes_left, bytes_left_next;
  logic [1:0]          ack_tries_left, ack_tries_left_next;
  logic [2:0]          last_status, last_status_next;
  logic                scl_drv, scl_drv_next;
  logic                sda_drv, sda_drv_next;
  i2c_mra_pkg::item_t  item, item_next;
  logic [6:0]          t_addr, t_addr_next;
  logic [7:0]          t_reg, t_reg_next;
  logic                t_read, t_read_next;

  i2c_mra_pkg::out_item_t res;
  logic                   accept;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    phase_next          = phase;
    tick_in_phase_next  = tick_in_phase;
    bit_counter_next    = bit_counter;
    shift_byte_next     = shift_byte;
    bytes_left_next     = bytes_left;
    ack_tries_left_next = ack_tries_left;
    last_status_next    = last_status;
    scl_drv_next        = scl_drv;
    sda_drv_next        = sda_drv;
    item_next           = item;
    t_addr_next         = t_addr;
    t_reg_next          = t_reg;
    t_read_next         = t_read;
    res                 = '0;

    // latch the configuration and enter START on the same tick
    if (phase == PH_IDLE && in_data.go) begin
      t_addr_next         = device_address;
      t_reg_next          = register_address;
      t_read_next         = read_mode;
      bytes_left_next     = byte_count;
      last_status_next    = i2c_mra_pkg::STATUS_OK;
      tick_in_phase_next  = 2'd0;
      bit_counter_next    = 4'd0;
      shift_byte_next     = 8'd0;
      ack_tries_left_next = 2'd0;
      item_next           = i2c_mra_pkg::ITEM_ADDR_W;
      phase_next          = PH_START;
    end
    res.busy_res = (phase_next != PH_IDLE);

    unique case (phase_next)
      PH_IDLE: begin
      end
      PH_START: begin
        unique case (tick_in_phase_next)
          2'd0:    sda_drv_next = 1'b1;
          2'd1:    scl_drv_next = 1'b1;
          2'd2:    sda_drv_next = 1'b0;
          default: scl_drv_next = 1'b0;
        endcase
        if (tick_in_phase_next == 2'd3) begin
          phase_next         = PH_SEND;
          tick_in_phase_next = 2'd0;
          bit_counter_next   = 4'd0;
          if (item_next == i2c_mra_pkg::ITEM_ADDR_R) begin
            shift_byte_next = {t_addr_next, 1'b1};
          end else begin
            shift_byte_next = {t_addr_next, 1'b0};
          end
        end else begin
          tick_in_phase_next = tick_in_phase_next + 2'd1;
        end
      end
      PH_SEND: begin
        if (tick_in_phase_next == 2'd0) begin
          if (item_next == i2c_mra_pkg::ITEM_DATA && bit_counter_next == 4'd0) begin
            shift_byte_next = in_data.tx_data;
            res.tx_taken    = 1'b1;
          end
          sda_drv_next       = shift_byte_next[7];
          tick_in_phase_next = 2'd1;
        end else if (tick_in_phase_next == 2'd1) begin
          scl_drv_next       = 1'b1;
          tick_in_phase_next = 2'd2;
        end else begin
          scl_drv_next       = 1'b0;
          shift_byte_next    = {shift_byte_next[6:0], 1'b0};
          tick_in_phase_next = 2'd0;
          if (bit_counter_next == 4'd7) begin
            bit_counter_next = 4'd0;
            phase_next       = PH_ACK;
          end else begin
            bit_counter_next = bit_counter_next + 4'd1;
          end
        end
      end
      PH_ACK: begin
        if (tick_in_phase_next == 2'd0) begin
          sda_drv_next       = 1'b1;
          tick_in_phase_next = 2'd1;
        end else if (tick_in_phase_next == 2'd1) begin
          scl_drv_next        = 1'b1;
          tick_in_phase_next  = 2'd2;
          ack_tries_left_next = i2c_mra_pkg::ACK_TRIES;
        end else begin
          res.sda_listening = 1'b1;
          if (ack_tries_left_next == 2'd0) begin
            // refused: report which byte and release the bus
            last_status_next   = i2c_mra_pkg::nack_status(item_next);
            phase_next         = PH_STOP;
            tick_in_phase_next = 2'd0;
          end else if (!in_data.sda_in) begin
            scl_drv_next = 1'b0;
            sda_drv_next = 1'b1;
            // pick the next byte; register and data bytes go straight to SEND, the read address via a repeated START
            unique case (item_next)
              i2c_mra_pkg::ITEM_ADDR_W: begin
                item_next          = i2c_mra_pkg::ITEM_REG;
                phase_next         = PH_SEND;
                tick_in_phase_next = 2'd0;
                bit_counter_next   = 4'd0;
                shift_byte_next    = t_reg_next;
              end
              i2c_mra_pkg::ITEM_REG: begin
                tick_in_phase_next = 2'd0;
                if (t_read_next) begin
                  phase_next = PH_START;
                  item_next  = i2c_mra_pkg::ITEM_ADDR_R;
                end else if (bytes_left_next == 16'd0) begin
                  phase_next = PH_STOP;
                end else begin
                  item_next        = i2c_mra_pkg::ITEM_DATA;
                  phase_next       = PH_SEND;
                  bit_counter_next = 4'd0;
                end
              end
              i2c_mra_pkg::ITEM_DATA: begin
                bytes_left_next    = bytes_left_next - 16'd1;
                tick_in_phase_next = 2'd0;
                if (bytes_left_next == 16'd0) begin
                  phase_next = PH_STOP;
                end else begin
                  phase_next       = PH_SEND;
                  bit_counter_next = 4'd0;
                end
              end
              default: begin
                tick_in_phase_next = 2'd0;
                if (bytes_left_next == 16'd0) begin
                  phase_next = PH_STOP;
                end else begin
                  phase_next       = PH_RECV;
                  bit_counter_next = 4'd0;
                  shift_byte_next  = 8'd0;
                end
              end
            endcase
          end else begin
            ack_tries_left_next = ack_tries_left_next - 2'd1;
          end
        end
      end
      PH_RECV: begin
        res.sda_listening = 1'b1;
        sda_drv_next      = 1'b1;
        if (tick_in_phase_next == 2'd0) begin
          scl_drv_next       = 1'b0;
          tick_in_phase_next = 2'd1;
        end else begin
          scl_drv_next       = 1'b1;
          shift_byte_next    = {shift_byte_next[6:0], in_data.sda_in};
          tick_in_phase_next = 2'd0;
          if (bit_counter_next == 4'd7) begin
            res.rx_valid     = 1'b1;
            res.rx_data      = shift_byte_next;
            bit_counter_next = 4'd0;
            bytes_left_next  = bytes_left_next - 16'd1;
            scl_drv_next     = 1'b0;
            phase_next       = PH_MACK;
          end else begin
            bit_counter_next = bit_counter_next + 4'd1;
          end
        end
      end
      PH_MACK: begin
        if (tick_in_phase_next == 2'd0) begin
          // NACK the last byte, ACK the rest
          sda_drv_next       = (bytes_left_next == 16'd0);
          tick_in_phase_next = 2'd1;
        end else if (tick_in_phase_next == 2'd1) begin
          scl_drv_next       = 1'b1;
          tick_in_phase_next = 2'd2;
        end else begin
          scl_drv_next       = 1'b0;
          tick_in_phase_next = 2'd0;
          if (bytes_left_next == 16'd0) begin
            phase_next = PH_STOP;
          end else begin
            phase_next       = PH_RECV;
            shift_byte_next  = 8'd0;
            bit_counter_next = 4'd0;
          end
        end
      end
      PH_STOP: begin
        if (tick_in_phase_next == 2'd0) begin
          sda_drv_next       = 1'b0;
          scl_drv_next       = 1'b0;
          tick_in_phase_next = 2'd1;
        end else if (tick_in_phase_next == 2'd1) begin
          scl_drv_next       = 1'b1;
          tick_in_phase_next = 2'd2;
        end else begin
          sda_drv_next       = 1'b1;
          res.done_res       = 1'b1;
          phase_next         = PH_IDLE;
          tick_in_phase_next = 2'd0;
        end
      end
      default: begin
      end
    endcase

    res.scl_level = scl_drv_next;
    res.sda_level = res.sda_listening | sda_drv_next;
    res.status    = last_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address   <= '0;
      register_address <= '0;
      byte_count       <= '0;
      read_mode        <= 1'b0;
      phase            <= PH_IDLE;
      tick_in_phase    <= '0;
      bit_counter      <= '0;
      shift_byte       <= '0;
      bytes_left       <= '0;
      ack_tries_left   <= '0;
      last_status      <= i2c_mra_pkg::STATUS_OK;
      scl_drv          <= 1'b1;
      sda_drv          <= 1'b1;
      item             <= i2c_mra_pkg::ITEM_ADDR_W;
      t_addr           <= '0;
      t_reg            <= '0;
      t_read           <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          i2c_mra_pkg::CFG_DEVICE_ADDRESS:   device_address   <= cfg_data[6:0];
          i2c_mra_pkg::CFG_REGISTER_ADDRESS: register_address <= cfg_data[7:0];
          i2c_mra_pkg::CFG_BYTE_COUNT:       byte_count       <= cfg_data;
          i2c_mra_pkg::CFG_READ_MODE:        read_mode        <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        phase          <= phase_next;
        tick_in_phase  <= tick_in_phase_next;
        bit_counter    <= bit_counter_next;
        shift_byte     <= shift_byte_next;
        bytes_left     <= bytes_left_next;
        ack_tries_left <= ack_tries_left_next;
        last_status    <= last_status_next;
        scl_drv        <= scl_drv_next;
        sda_drv        <= sda_drv_next;
        item           <= item_next;
        t_addr         <= t_addr_next;
        t_reg          <= t_reg_next;
        t_read         <= t_read_next;
        out_data       <= res;
      end
      // hold the result until the consumer takes it
      out_valid <= accept | (out_valid & out_stall);
    end
  end

  // every accepted tick leaves a result behind
  a_accept_fills_output: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted tick produced no result");

  a_idle_counters_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> (tick_in_phase == 2'd0 && bit_counter == 4'd0))
    else $error("sequencer idle with counters not cleared");

  a_bit_counter_range: assert property (@(posedge clk) disable iff (rst)
    bit_counter <= 4'd7)
    else $error("bit counter out of range");

  a_rx_while_listening: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.rx_valid) |-> (out_data.sda_listening && out_data.busy_res))
    else $error("received byte reported while not listening");

endmodule

`default_nettype wire
